/* rtl/mtg_pkg.sv */
// shared constants, field widths, codes and controller/datapath link types
// for the multitone generator with mu-law encoder; depends on nothing
package mtg_pkg;

    // sizing
    localparam int NUM_TONES      = 10;
    localparam int SINE_ADDR_BITS = 10;
    localparam int INDEX_BITS     = 24;

    // item field widths
    localparam int FUNC_W   = 2;
    localparam int SLOT_W   = 4;
    localparam int STEP_W   = 16;
    localparam int GAIN_W   = 15;
    localparam int WIN_W    = 24;
    localparam int ACTIVE_W = 4;
    localparam int ULAW_W   = 8;
    localparam int LIN_W    = 18;

    // derived widths
    localparam int TONE_W  = (NUM_TONES > 1) ? $clog2(NUM_TONES) : 1;
    localparam int COUNT_W = $clog2(NUM_TONES + 1);
    localparam int CMP_W   = (INDEX_BITS > WIN_W) ? INDEX_BITS : WIN_W;
    localparam int Z_W     = 15;                    // quarter-wave argument, 0..16384
    localparam int T1_W    = 11;
    localparam int T2_W    = 14;
    localparam int PROD_W  = 2 * GAIN_W + 1;        // signed gain times sine
    localparam int ACC_W   = PROD_W + $clog2(NUM_TONES);
    localparam int ACC_SHIFT = 15;
    localparam int MAG_W   = ACC_W - ACC_SHIFT;
    localparam int MB_W    = MAG_W + 1;
    localparam int PIPE_DEPTH = 7;

    // sine polynomial constants (q14)
    localparam logic [15:0] SINE_MASK = 16'(16'hffff << (16 - SINE_ADDR_BITS));
    localparam logic [Z_W-1:0]  Q14_ONE = 15'd16384;
    localparam logic [T1_W-1:0] SIN_C1  = 11'd1192;
    localparam logic [T2_W-1:0] SIN_C2  = 14'd10544;
    localparam logic [Z_W-1:0]  SIN_C3  = 15'd25736;

    // encoder constants
    localparam int FULL_SCALE = 'h2000;
    localparam int ULAW_BIAS  = 33;
    localparam int SEG_LSB    = 5;
    localparam logic [6:0] ULAW_SAT_CODE  = 7'h7f;
    localparam logic [ULAW_W-1:0] ULAW_INV      = 8'hff;
    localparam logic [ULAW_W-1:0] ULAW_ZERO_SUB = 8'd2;
    localparam int LIN_MAX     = 131071;
    localparam int LIN_MIN_MAG = 131072;
    localparam logic [LIN_W-1:0] LIN_MAX_CODE = 18'h1ffff;
    localparam logic [LIN_W-1:0] LIN_MIN_CODE = 18'h20000;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD    = 2'd0,
        FUNC_TONE    = 2'd1,
        FUNC_QUIET   = 2'd2,
        FUNC_RESTART = 2'd3
    } func_t;

    // controller to datapath
    typedef struct packed {
        logic              load_we;
        logic              idx_clear;
        logic              acc_clear;
        logic              issue;
        logic [TONE_W-1:0] tone;
        logic              fin;
        logic              out_load;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic busy;
        logic out_free;
    } dp_sts_t;

endpackage

/* rtl/mtg_if.sv */
// channel interfaces for the multitone generator: tone items in, samples out
// and the configuration write channel; depends on mtg_pkg
interface mtg_in_if;
    logic                          valid;
    logic                          ready;
    mtg_pkg::func_t                func;
    logic [mtg_pkg::SLOT_W-1:0]    slot;
    logic [mtg_pkg::STEP_W-1:0]    phase_step;
    logic [mtg_pkg::GAIN_W-1:0]    gain;
    logic [mtg_pkg::WIN_W-1:0]     window_start;
    logic [mtg_pkg::WIN_W-1:0]     window_stop;

    modport source (output valid, func, slot, phase_step, gain, window_start, window_stop,
                    input ready);
    modport sink   (input valid, func, slot, phase_step, gain, window_start, window_stop,
                    output ready);
endinterface

interface mtg_out_if;
    logic                              valid;
    logic                              ready;
    logic [mtg_pkg::ULAW_W-1:0]        ulaw_code;
    logic signed [mtg_pkg::LIN_W-1:0]  linear_sample;

    modport source (output valid, ulaw_code, linear_sample, input ready);
    modport sink   (input valid, ulaw_code, linear_sample, output ready);
endinterface

interface mtg_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [mtg_pkg::ACTIVE_W-1:0]   active_tones;

    modport source (output valid, active_tones, input ready);
    modport sink   (input valid, active_tones, output ready);
endinterface

/* rtl/mtg_datapath.sv */
// tone table, sine/gain pipeline, accumulator, mu-law encoder and output register
// depends on mtg_pkg
module mtg_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [mtg_pkg::SLOT_W-1:0]        slot,
    input  logic [mtg_pkg::STEP_W-1:0]        phase_step,
    input  logic [mtg_pkg::GAIN_W-1:0]        gain,
    input  logic [mtg_pkg::WIN_W-1:0]         window_start,
    input  logic [mtg_pkg::WIN_W-1:0]         window_stop,
    input  mtg_pkg::dp_cmd_t                  cmd,
    output mtg_pkg::dp_sts_t                  sts,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [mtg_pkg::ULAW_W-1:0]        ulaw_code,
    output logic signed [mtg_pkg::LIN_W-1:0]  linear_sample
);

    // tone table, undefined until loaded
    logic [mtg_pkg::STEP_W-1:0] tone_step_reg  [mtg_pkg::NUM_TONES];
    logic [mtg_pkg::GAIN_W-1:0] tone_gain_reg  [mtg_pkg::NUM_TONES];
    logic [mtg_pkg::WIN_W-1:0]  tone_begin_reg [mtg_pkg::NUM_TONES];
    logic [mtg_pkg::WIN_W-1:0]  tone_end_reg   [mtg_pkg::NUM_TONES];

    logic [mtg_pkg::INDEX_BITS-1:0] idx_reg;
    logic [mtg_pkg::PIPE_DEPTH-1:0] vld_reg;

    // stage registers
    logic [15:0]                 s1_ph_reg;
    logic [mtg_pkg::GAIN_W-1:0]  s1_gain_reg;
    logic                        s1_act_reg;
    logic [mtg_pkg::Z_W-1:0]     s2_z_reg, s3_z_reg, s4_z_reg, s5_z_reg;
    logic [mtg_pkg::Z_W-1:0]     s2_z2_reg, s3_z2_reg, s4_z2_reg;
    logic [mtg_pkg::T1_W-1:0]    s4_t1_reg;
    logic [mtg_pkg::T2_W-1:0]    s5_t2_reg;
    logic [mtg_pkg::Z_W-1:0]     s6_sine_reg;
    logic [mtg_pkg::GAIN_W-1:0]  s2_gain_reg, s3_gain_reg, s4_gain_reg, s5_gain_reg;
    logic [mtg_pkg::GAIN_W-1:0]  s6_gain_reg;
    logic                        s2_act_reg, s3_act_reg, s4_act_reg, s5_act_reg, s6_act_reg;
    logic                        s2_neg_reg, s3_neg_reg, s4_neg_reg, s5_neg_reg, s6_neg_reg;
    logic signed [mtg_pkg::PROD_W-1:0] prod_reg;
    logic signed [mtg_pkg::ACC_W-1:0]  acc_reg;

    logic                        fin_neg_reg;
    logic [mtg_pkg::MAG_W-1:0]   fin_mag_reg;

    logic [mtg_pkg::ULAW_W-1:0]        ulaw_reg;
    logic signed [mtg_pkg::LIN_W-1:0]  lin_reg;
    logic                              out_valid_reg;

    // stage 0: table read, window test, phase
    logic [mtg_pkg::CMP_W-1:0]   idx_cmp;
    logic                        in_win;
    logic [2*mtg_pkg::STEP_W-1:0] ph_prod;
    logic                        slot_ok;

    // stage 1..6
    logic [15:0]                 q;
    logic [mtg_pkg::Z_W-1:0]     z;
    logic [2*mtg_pkg::Z_W-1:0]   zz;
    logic [mtg_pkg::T1_W+mtg_pkg::Z_W-1:0] p1;
    logic [mtg_pkg::T2_W-1:0]    d2;
    logic [mtg_pkg::T2_W+mtg_pkg::Z_W-1:0] p2;
    logic [mtg_pkg::Z_W-1:0]     d3;
    logic [2*mtg_pkg::Z_W-1:0]   p3;
    logic [2*mtg_pkg::GAIN_W-1:0] gp;
    logic signed [mtg_pkg::PROD_W-1:0] gp_s;

    // finalise
    logic [mtg_pkg::ACC_W-1:0]   acc_abs;
    logic [mtg_pkg::MAG_W-1:0]   acc_mag;
    logic [mtg_pkg::LIN_W-1:0]   lin_mag;
    logic [mtg_pkg::LIN_W-1:0]   lin_val;
    logic [mtg_pkg::MB_W-1:0]    mb;
    logic [2:0]                  seg;
    logic [3:0]                  shamt;
    logic [3:0]                  mant;
    logic [6:0]                  mcode;
    logic [mtg_pkg::ULAW_W-1:0]  ulaw_val;

    always_comb
    begin
        idx_cmp = mtg_pkg::CMP_W'(idx_reg);
        in_win  = (idx_cmp >= mtg_pkg::CMP_W'(tone_begin_reg[cmd.tone]))
               && (idx_cmp <  mtg_pkg::CMP_W'(tone_end_reg[cmd.tone]));
        ph_prod = idx_reg[mtg_pkg::STEP_W-1:0] * tone_step_reg[cmd.tone];
        slot_ok = (32'(slot) < 32'(mtg_pkg::NUM_TONES));
    end

    always_comb
    begin
        // quarter-wave fold of the table point
        q  = s1_ph_reg & mtg_pkg::SINE_MASK;
        z  = q[14] ? (mtg_pkg::Q14_ONE - {1'b0, q[13:0]}) : {1'b0, q[13:0]};
        zz = z * z;
        p1 = mtg_pkg::SIN_C1 * s3_z2_reg;
        d2 = mtg_pkg::SIN_C2 - mtg_pkg::T2_W'(s4_t1_reg);
        p2 = d2 * s4_z2_reg;
        d3 = mtg_pkg::SIN_C3 - mtg_pkg::Z_W'(s5_t2_reg);
        p3 = d3 * s5_z_reg;
        gp = s6_gain_reg * s6_sine_reg;
        gp_s = $signed({1'b0, gp});
    end

    always_comb
    begin
        acc_abs = acc_reg[mtg_pkg::ACC_W-1] ? mtg_pkg::ACC_W'(-acc_reg)
                                            : mtg_pkg::ACC_W'(acc_reg);
        acc_mag = acc_abs[mtg_pkg::ACC_W-1:mtg_pkg::ACC_SHIFT];
    end

    // linear saturation and mu-law encoding from the registered magnitude
    always_comb
    begin
        lin_mag = mtg_pkg::LIN_W'(fin_mag_reg);
        if (!fin_neg_reg && 32'(fin_mag_reg) > 32'(mtg_pkg::LIN_MAX))
        begin
            lin_val = mtg_pkg::LIN_MAX_CODE;
        end
        else if (fin_neg_reg && 32'(fin_mag_reg) > 32'(mtg_pkg::LIN_MIN_MAG))
        begin
            lin_val = mtg_pkg::LIN_MIN_CODE;
        end
        else
        begin
            lin_val = fin_neg_reg ? (mtg_pkg::LIN_W'(0) - lin_mag) : lin_mag;
        end

        mb  = {1'b0, fin_mag_reg} + mtg_pkg::MB_W'(mtg_pkg::ULAW_BIAS);
        seg = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (mb[mtg_pkg::SEG_LSB + i])
            begin
                seg = 3'(i);
            end
        end
        shamt = {1'b0, seg} + 4'd1;
        mant  = 4'(mb >> shamt);
        if (mb >= mtg_pkg::MB_W'(mtg_pkg::FULL_SCALE))
        begin
            mcode = mtg_pkg::ULAW_SAT_CODE;
        end
        else
        begin
            mcode = {seg, mant};
        end
        ulaw_val = {fin_neg_reg, mcode} ^ mtg_pkg::ULAW_INV;
        if (ulaw_val == '0)
        begin
            ulaw_val = mtg_pkg::ULAW_ZERO_SUB;
        end
    end

    // table writes
    always_ff @(posedge clk)
    begin
        if (cmd.load_we && slot_ok)
        begin
            tone_step_reg[slot[mtg_pkg::TONE_W-1:0]]  <= phase_step;
            tone_gain_reg[slot[mtg_pkg::TONE_W-1:0]]  <= gain;
            tone_begin_reg[slot[mtg_pkg::TONE_W-1:0]] <= window_start;
            tone_end_reg[slot[mtg_pkg::TONE_W-1:0]]   <= window_stop;
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        s1_ph_reg   <= ph_prod[15:0];
        s1_gain_reg <= tone_gain_reg[cmd.tone];
        s1_act_reg  <= in_win;

        s2_z_reg    <= z;
        s2_z2_reg   <= zz[28:14];
        s2_neg_reg  <= q[15];
        s2_gain_reg <= s1_gain_reg;
        s2_act_reg  <= s1_act_reg;

        s3_z_reg    <= s2_z_reg;
        s3_z2_reg   <= s2_z2_reg;
        s3_neg_reg  <= s2_neg_reg;
        s3_gain_reg <= s2_gain_reg;
        s3_act_reg  <= s2_act_reg;

        s4_t1_reg   <= p1[24:14];
        s4_z_reg    <= s3_z_reg;
        s4_z2_reg   <= s3_z2_reg;
        s4_neg_reg  <= s3_neg_reg;
        s4_gain_reg <= s3_gain_reg;
        s4_act_reg  <= s3_act_reg;

        s5_t2_reg   <= p2[27:14];
        s5_z_reg    <= s4_z_reg;
        s5_neg_reg  <= s4_neg_reg;
        s5_gain_reg <= s4_gain_reg;
        s5_act_reg  <= s4_act_reg;

        s6_sine_reg <= p3[28:14];
        s6_neg_reg  <= s5_neg_reg;
        s6_gain_reg <= s5_gain_reg;
        s6_act_reg  <= s5_act_reg;

        if (!s6_act_reg)
        begin
            prod_reg <= '0;
        end
        else
        begin
            prod_reg <= s6_neg_reg ? -gp_s : gp_s;
        end

        if (cmd.fin)
        begin
            fin_neg_reg <= acc_reg[mtg_pkg::ACC_W-1] && (acc_mag != '0);
            fin_mag_reg <= acc_mag;
        end

        if (cmd.out_load)
        begin
            ulaw_reg <= ulaw_val;
            lin_reg  <= $signed(lin_val);
        end
    end

    // control state of the datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            idx_reg       <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= {vld_reg[mtg_pkg::PIPE_DEPTH-2:0], cmd.issue};

            if (cmd.idx_clear)
            begin
                idx_reg <= '0;
            end
            else if (cmd.fin)
            begin
                idx_reg <= idx_reg + mtg_pkg::INDEX_BITS'(1);
            end

            if (cmd.acc_clear)
            begin
                acc_reg <= '0;
            end
            else if (vld_reg[mtg_pkg::PIPE_DEPTH-1])
            begin
                acc_reg <= acc_reg + mtg_pkg::ACC_W'(prod_reg);
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.busy      = |vld_reg;
    assign sts.out_free  = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign ulaw_code     = ulaw_reg;
    assign linear_sample = lin_reg;

`ifndef SYNTHESIS
    a_code_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (ulaw_reg != '0))
        else $error("mu-law byte of zero presented");

    a_index_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!cmd.fin && !cmd.idx_clear) |=> $stable(idx_reg))
        else $error("sample index moved without a sample or restart");
`endif

endmodule

/* rtl/mtg_ctrl.sv */
// controller for the multitone generator: item decode, tone issue sequencing,
// active tone count register; depends on mtg_pkg
module mtg_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  mtg_pkg::func_t                  in_func,
    output logic                            in_ready,
    input  logic                            cfg_valid,
    input  logic [mtg_pkg::ACTIVE_W-1:0]    cfg_data,
    output logic                            cfg_ready,
    output mtg_pkg::dp_cmd_t                cmd,
    input  mtg_pkg::dp_sts_t                sts
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_FINAL,
        ST_OUTPUT
    } state_t;

    state_t                         state_reg, state_next;
    logic [mtg_pkg::TONE_W-1:0]     tone_reg, tone_next;
    logic [mtg_pkg::COUNT_W-1:0]    count_reg, count_next;
    logic                           in_acc;
    logic                           last_tone;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = in_valid && in_ready;
    assign last_tone = (mtg_pkg::COUNT_W'(tone_reg) + mtg_pkg::COUNT_W'(1)) == count_reg;

    always_comb
    begin
        state_next = state_reg;
        tone_next  = tone_reg;
        count_next = count_reg;
        cmd        = '0;
        cmd.tone   = tone_reg;

        if (cfg_valid)
        begin
            // counts above the table size use the whole table
            if (32'(cfg_data) > 32'(mtg_pkg::NUM_TONES))
            begin
                count_next = mtg_pkg::COUNT_W'(mtg_pkg::NUM_TONES);
            end
            else
            begin
                count_next = mtg_pkg::COUNT_W'(cfg_data);
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    case (in_func)
                        mtg_pkg::FUNC_LOAD:    cmd.load_we   = 1'b1;
                        mtg_pkg::FUNC_RESTART: cmd.idx_clear = 1'b1;
                        mtg_pkg::FUNC_TONE:
                        begin
                            cmd.acc_clear = 1'b1;
                            tone_next     = '0;
                            state_next    = (count_reg == '0) ? ST_FINAL : ST_ISSUE;
                        end
                        mtg_pkg::FUNC_QUIET:
                        begin
                            cmd.acc_clear = 1'b1;
                            state_next    = ST_FINAL;
                        end
                        default: ;
                    endcase
                end
            end
            ST_ISSUE:
            begin
                cmd.issue = 1'b1;
                if (last_tone)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    tone_next = tone_reg + mtg_pkg::TONE_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!sts.busy)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                cmd.fin    = 1'b1;
                state_next = ST_OUTPUT;
            end
            ST_OUTPUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            tone_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tone_reg  <= tone_next;
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_accept_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> !sts.busy)
        else $error("item taken while tones still in flight");

    a_load_into_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result register overwritten before it was taken");

    a_first_issue: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && in_func == mtg_pkg::FUNC_TONE && count_reg != '0)
            |=> (cmd.issue && cmd.tone == '0))
        else $error("tone sample did not start at slot zero");
`endif

endmodule

/* rtl/multitone_generator_mulaw.sv */
// top level of the multitone test-tone generator with biased mu-law encoder
// depends on mtg_pkg, mtg_if, mtg_ctrl, mtg_datapath
//
//  channel     dir  carries
//  ----------  ---  ----------------------------------------------------------
//  cfg         in   active_tones (number of table slots summed per sample)
//  tone_in     in   func, slot, phase_step, gain, window_start, window_stop
//  sample_out  out  ulaw_code, linear_sample
//
//  load, restart: taken without leaving idle, no result
//  quiet sample: through the finalise and output states to the output register
//  tone sample: one tone enters the shared seven-stage sine and gain multiply
//    pipeline each cycle, then the accumulator drains, then the sum is scaled
//    in the finalise state and encoded into the output register; the next
//    item is taken the cycle after the output register loads
//  reset clears the sample index, the tone count and all valid flags; the
//    tone table is not cleared. a stalled output holds its sample while the
//    next item may already be taken; that item waits before its own result
module multitone_generator_mulaw (
    input  logic       clk,
    input  logic       rst_n,
    mtg_cfg_if.sink    cfg,
    mtg_in_if.sink     tone_in,
    mtg_out_if.source  sample_out
);

    // command and status between the sequencer and the datapath
    mtg_pkg::dp_cmd_t cmd;
    mtg_pkg::dp_sts_t sts;

    // sequencer: item decode, per-tone issue, drain, finalise and output hand-off
    mtg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (tone_in.valid),
        .in_func   (tone_in.func),
        .in_ready  (tone_in.ready),
        .cfg_valid (cfg.valid),
        .cfg_data  (cfg.active_tones),
        .cfg_ready (cfg.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // datapath: tone table, sine polynomial pipeline, accumulator, encoder
    mtg_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .slot          (tone_in.slot),
        .phase_step    (tone_in.phase_step),
        .gain          (tone_in.gain),
        .window_start  (tone_in.window_start),
        .window_stop   (tone_in.window_stop),
        .cmd           (cmd),
        .sts           (sts),
        .out_valid     (sample_out.valid),
        .out_ready     (sample_out.ready),
        .ulaw_code     (sample_out.ulaw_code),
        .linear_sample (sample_out.linear_sample)
    );

endmodule
